// ===== sv/bba_pkg.sv =====
package bba_pkg;

    localparam int MIN_BITS   = 10;
    localparam int MAX_BITS   = 22;
    localparam int POOL_UNITS = 16384;
    localparam int NORD       = MAX_BITS - MIN_BITS + 1;

    localparam int UNIT_W = 14;             // unit index
    localparam int CNT_W  = 15;             // unit count, 0..POOL_UNITS
    localparam int ORD_W  = 4;
    localparam int LINK_W = 15;             // unit index plus nil code
    localparam int TOT_W  = 26;             // rounded request plus overhead
    localparam int CFG_W  = 15;

    localparam logic [LINK_W-1:0] LINK_NIL = '1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BIG     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic CFG_POOL = 1'b0;
    localparam logic CFG_OVH  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [23:0]       request_bytes;
        logic [UNIT_W-1:0] block_unit;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [UNIT_W-1:0] result_unit;
        logic [ORD_W-1:0]  result_order;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_START,
        OP_CLR,
        OP_CV_ADV,
        OP_CV_DEC,
        OP_CV_DONE,
        OP_PT1,
        OP_PT2,
        OP_LOAD,
        OP_A_ORD,
        OP_A_FIND,
        OP_A_HEAD,
        OP_A_DEC,
        OP_A_HI,
        OP_A_TAKE,
        OP_UL_RD,
        OP_UL_WR,
        OP_ST_RD_U,
        OP_F_MARK,
        OP_ST_RD_B,
        OP_F_UP,
        OP_PH1,
        OP_PH2,
        OP_RES
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] res;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic cv_fit;
        logic k_zero;
        logic is_free;
        logic too_big;
        logic found;
        logic k_gt_ord;
        logic range_bad;
        logic st_free;
        logic k_top;
        logic b_out;
        logic merge_ok;
    } sts_t;

endpackage

// ===== sv/bba_dpath.sv =====
module bba_dpath
    import bba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  req_t              s_data,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output rsp_t              m_data
);

    typedef struct packed {
        logic [ORD_W-1:0] ord;
        logic             fr;
    } ust_t;

    // unit state and link memories
    ust_t              st_mem [POOL_UNITS];
    logic [LINK_W-1:0] nx_mem [POOL_UNITS];
    logic [LINK_W-1:0] pv_mem [POOL_UNITS];

    ust_t              st_rd_reg;
    logic [LINK_W-1:0] nx_rd_reg, pv_rd_reg;

    logic [LINK_W-1:0] head_reg [NORD];
    logic [LINK_W-1:0] tail_reg [NORD];

    logic [CNT_W-1:0]  pool_reg, pend_reg, t_reg;
    logic [11:0]       ovh_reg;
    logic [UNIT_W-1:0] clr_reg, u_reg, b_reg;
    logic [ORD_W-1:0]  k_reg, ord_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              free_reg;
    rsp_t              out_reg;

    // write/read port controls
    logic              st_we, st_re, lk_re, nx_we, pv_we;
    logic [UNIT_W-1:0] st_wa, st_ra, nx_wa, pv_wa;
    ust_t              st_wd;
    logic [LINK_W-1:0] nx_wd, pv_wd;
    logic              hd_we, tl_we;
    logic [LINK_W-1:0] hd_wd, tl_wd;

    logic [UNIT_W-1:0] bud, umin;
    logic [LINK_W-1:0] head_k, tail_k, u_link;
    logic              fnd;
    logic [ORD_W-1:0]  fk, raw_cap;
    logic [TOT_W-1:0]  total_in;

    function automatic logic [ORD_W-1:0] need_order(input logic [TOT_W-1:0] tot);
        logic [ORD_W-1:0] o;
        o = ORD_W'(NORD - 1);
        for (int i = NORD - 1; i >= 0; i--) begin
            if (tot <= (TOT_W'(1) << (MIN_BITS + i))) begin
                o = ORD_W'(i);
            end
        end
        return o;
    endfunction

    assign head_k = head_reg[k_reg];
    assign tail_k = tail_reg[k_reg];
    assign u_link = {1'b0, u_reg};
    assign bud    = u_reg ^ (UNIT_W'(1) << k_reg);
    assign umin   = (b_reg < u_reg) ? b_reg : u_reg;
    assign raw_cap = (st_rd_reg.ord > ORD_W'(NORD - 1)) ? ORD_W'(NORD - 1) : st_rd_reg.ord;

    assign total_in = ((TOT_W'(s_data.request_bytes) + TOT_W'(7)) & ~TOT_W'(7))
                      + TOT_W'(ovh_reg);

    // lowest non-empty list at or above the needed order
    always_comb begin
        fnd = 1'b0;
        fk  = '0;
        for (int i = NORD - 1; i >= 0; i--) begin
            if (ORD_W'(i) >= ord_reg && head_reg[i] != LINK_NIL) begin
                fnd = 1'b1;
                fk  = ORD_W'(i);
            end
        end
    end

    always_comb begin
        sts.clr_last  = (clr_reg == UNIT_W'(POOL_UNITS - 1));
        sts.cv_fit    = ((CNT_W + 1)'(t_reg) + ((CNT_W + 1)'(1) << k_reg))
                        <= (CNT_W + 1)'(pool_reg);
        sts.k_zero    = (k_reg == '0);
        sts.is_free   = free_reg;
        sts.too_big   = (total_reg > (TOT_W'(1) << MAX_BITS));
        sts.found     = fnd;
        sts.k_gt_ord  = (k_reg > ord_reg);
        sts.range_bad = ({1'b0, u_reg} >= pend_reg);
        sts.st_free   = st_rd_reg.fr;
        sts.k_top     = (k_reg == ORD_W'(NORD - 1));
        sts.b_out     = ({1'b0, bud} >= pend_reg);
        sts.merge_ok  = st_rd_reg.fr && (st_rd_reg.ord == k_reg);
    end

    always_comb begin
        st_we = 1'b0; st_wa = u_reg; st_wd = '{ord: k_reg, fr: 1'b1};
        st_re = 1'b0; st_ra = u_reg;
        lk_re = 1'b0;
        nx_we = 1'b0; nx_wa = t_reg[UNIT_W-1:0]; nx_wd = LINK_NIL;
        pv_we = 1'b0; pv_wa = t_reg[UNIT_W-1:0]; pv_wd = LINK_NIL;
        hd_we = 1'b0; hd_wd = LINK_NIL;
        tl_we = 1'b0; tl_wd = LINK_NIL;
        unique case (cmd.op)
            OP_CLR: begin
                st_we = 1'b1;
                st_wa = clr_reg;
                st_wd = '{ord: '0, fr: 1'b1};
            end
            OP_PT1: begin
                st_we = 1'b1;
                st_wa = t_reg[UNIT_W-1:0];
                nx_we = 1'b1;
                pv_we = 1'b1;
                pv_wd = tail_k;
            end
            OP_PT2: begin
                if (tail_k == LINK_NIL) begin
                    hd_we = 1'b1;
                    hd_wd = t_reg;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = tail_k[UNIT_W-1:0];
                    nx_wd = t_reg;
                end
                tl_we = 1'b1;
                tl_wd = t_reg;
            end
            OP_UL_RD: lk_re = 1'b1;
            OP_UL_WR: begin
                if (pv_rd_reg == LINK_NIL) begin
                    hd_we = 1'b1;
                    hd_wd = nx_rd_reg;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = pv_rd_reg[UNIT_W-1:0];
                    nx_wd = nx_rd_reg;
                end
                if (nx_rd_reg == LINK_NIL) begin
                    tl_we = 1'b1;
                    tl_wd = pv_rd_reg;
                end else begin
                    pv_we = 1'b1;
                    pv_wa = nx_rd_reg[UNIT_W-1:0];
                    pv_wd = pv_rd_reg;
                end
            end
            OP_A_TAKE: begin
                st_we = 1'b1;
                st_wd = '{ord: ord_reg, fr: 1'b0};
            end
            OP_ST_RD_U: st_re = 1'b1;
            OP_ST_RD_B: begin
                st_re = 1'b1;
                st_ra = bud;
            end
            OP_F_MARK: begin
                st_we = 1'b1;
                st_wd = '{ord: st_rd_reg.ord, fr: 1'b1};
            end
            OP_F_UP: begin
                st_we = 1'b1;
                st_wa = umin;
                st_wd = '{ord: k_reg + ORD_W'(1), fr: 1'b1};
            end
            OP_PH1: begin
                st_we = 1'b1;
                nx_we = 1'b1;
                nx_wa = u_reg;
                nx_wd = head_k;
                pv_we = 1'b1;
                pv_wa = u_reg;
            end
            OP_PH2: begin
                if (head_k == LINK_NIL) begin
                    tl_we = 1'b1;
                    tl_wd = u_link;
                end else begin
                    pv_we = 1'b1;
                    pv_wa = head_k[UNIT_W-1:0];
                    pv_wd = u_link;
                end
                hd_we = 1'b1;
                hd_wd = u_link;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_we) st_mem[st_wa] <= st_wd;
        if (st_re) st_rd_reg <= st_mem[st_ra];
    end

    always_ff @(posedge aclk) begin
        if (nx_we) nx_mem[nx_wa] <= nx_wd;
        if (lk_re) nx_rd_reg <= nx_mem[b_reg];
    end

    always_ff @(posedge aclk) begin
        if (pv_we) pv_mem[pv_wa] <= pv_wd;
        if (lk_re) pv_rd_reg <= pv_mem[b_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.op == OP_CLR_START) begin
            for (int i = 0; i < NORD; i++) begin
                head_reg[i] <= LINK_NIL;
                tail_reg[i] <= LINK_NIL;
            end
        end else begin
            if (hd_we) head_reg[k_reg] <= hd_wd;
            if (tl_we) tail_reg[k_reg] <= tl_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= CNT_W'(POOL_UNITS);
            ovh_reg  <= 12'd352;
            pend_reg <= '0;
            clr_reg  <= '0;
            t_reg    <= '0;
            k_reg    <= '0;
        end else begin
            if (cfg_we && cfg_idx == CFG_POOL) begin
                pool_reg <= (cfg_wdata > CFG_W'(POOL_UNITS)) ? CNT_W'(POOL_UNITS)
                                                             : CNT_W'(cfg_wdata);
            end
            if (cfg_we && cfg_idx == CFG_OVH) begin
                ovh_reg <= cfg_wdata[11:0];
            end
            unique case (cmd.op)
                OP_CLR_START: begin
                    clr_reg <= '0;
                    t_reg   <= '0;
                    k_reg   <= ORD_W'(NORD - 1);
                end
                OP_CLR:     clr_reg <= clr_reg + UNIT_W'(1);
                OP_CV_ADV:  t_reg <= t_reg + (CNT_W'(1) << k_reg);
                OP_CV_DEC:  k_reg <= k_reg - ORD_W'(1);
                OP_CV_DONE: pend_reg <= t_reg;
                OP_LOAD: begin
                    free_reg  <= s_data.req_type;
                    u_reg     <= s_data.block_unit;
                    total_reg <= total_in;
                end
                OP_A_ORD:  ord_reg <= need_order(total_reg);
                OP_A_FIND: k_reg <= fk;
                OP_A_HEAD: begin
                    u_reg <= head_k[UNIT_W-1:0];
                    b_reg <= head_k[UNIT_W-1:0];
                end
                OP_A_DEC: begin
                    k_reg <= k_reg - ORD_W'(1);
                    t_reg <= {1'b0, u_reg};
                end
                OP_A_HI:    t_reg <= {1'b0, u_reg} + (CNT_W'(1) << k_reg);
                OP_F_MARK:  k_reg <= raw_cap;
                OP_ST_RD_B: b_reg <= bud;
                OP_F_UP: begin
                    u_reg <= umin;
                    k_reg <= k_reg + ORD_W'(1);
                end
                OP_RES: begin
                    out_reg.status       <= cmd.res;
                    out_reg.result_unit  <= (cmd.res == ST_OK) ? u_reg : '0;
                    out_reg.result_order <= (cmd.res == ST_OK)   ? k_reg :
                                            (cmd.res == ST_FULL) ? ord_reg : '0;
                end
                default: ;
            endcase
        end
    end

    assign m_data = out_reg;

endmodule

// ===== sv/bba_ctrl.sv =====
module bba_ctrl
    import bba_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic pool_wr,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_CLR_START, S_CLR, S_CV_TEST, S_CV_PT1, S_CV_PT2, S_CV_ADV, S_CV_DEC,
        S_CV_DONE, S_IDLE, S_DISP, S_A_FIND, S_A_HEAD, S_A_ULRD, S_A_ULWR,
        S_A_DEC, S_A_PT1A, S_A_PT2A, S_A_HI, S_A_PT1B, S_A_PT2B, S_A_TAKE,
        S_F_RDU, S_F_CHK, S_F_LOOP, S_F_BCHK, S_F_ULRD, S_F_ULWR, S_F_UP,
        S_F_PH1, S_F_PH2, S_RES
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] res_reg, res_next;
    logic       mv_reg, mv_next;
    dp_op_t     op;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        mv_next    = mv_reg && !m_ready;
        op         = OP_NONE;
        unique case (state_reg)
            S_CLR_START: begin
                op = OP_CLR_START;
                state_next = S_CLR;
            end
            S_CLR: begin
                op = OP_CLR;
                if (sts.clr_last) state_next = S_CV_TEST;
            end
            S_CV_TEST: begin
                priority if (sts.cv_fit) state_next = S_CV_PT1;
                else if (sts.k_zero)    state_next = S_CV_DONE;
                else                    state_next = S_CV_DEC;
            end
            S_CV_PT1: begin op = OP_PT1;     state_next = S_CV_PT2;  end
            S_CV_PT2: begin op = OP_PT2;     state_next = S_CV_ADV;  end
            S_CV_ADV: begin op = OP_CV_ADV;  state_next = S_CV_TEST; end
            S_CV_DEC: begin op = OP_CV_DEC;  state_next = S_CV_TEST; end
            S_CV_DONE: begin op = OP_CV_DONE; state_next = S_IDLE;   end
            S_IDLE: begin
                if (s_valid) begin
                    op = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (sts.is_free) begin
                    if (sts.range_bad) begin
                        res_next = ST_BADFREE;
                        state_next = S_RES;
                    end else begin
                        state_next = S_F_RDU;
                    end
                end else if (sts.too_big) begin
                    res_next = ST_BIG;
                    state_next = S_RES;
                end else begin
                    op = OP_A_ORD;
                    state_next = S_A_FIND;
                end
            end
            S_A_FIND: begin
                if (sts.found) begin
                    op = OP_A_FIND;
                    state_next = S_A_HEAD;
                end else begin
                    res_next = ST_FULL;
                    state_next = S_RES;
                end
            end
            S_A_HEAD: begin op = OP_A_HEAD; state_next = S_A_ULRD; end
            S_A_ULRD: begin op = OP_UL_RD;  state_next = S_A_ULWR; end
            S_A_ULWR: begin
                op = OP_UL_WR;
                state_next = sts.k_gt_ord ? S_A_DEC : S_A_TAKE;
            end
            S_A_DEC:  begin op = OP_A_DEC; state_next = S_A_PT1A; end
            S_A_PT1A: begin op = OP_PT1;   state_next = S_A_PT2A; end
            S_A_PT2A: begin op = OP_PT2;   state_next = S_A_HI;   end
            S_A_HI:   begin op = OP_A_HI;  state_next = S_A_PT1B; end
            S_A_PT1B: begin op = OP_PT1;   state_next = S_A_PT2B; end
            S_A_PT2B: begin op = OP_PT2;   state_next = S_A_HEAD; end
            S_A_TAKE: begin
                op = OP_A_TAKE;
                res_next = ST_OK;
                state_next = S_RES;
            end
            S_F_RDU: begin op = OP_ST_RD_U; state_next = S_F_CHK; end
            S_F_CHK: begin
                if (sts.st_free) begin
                    res_next = ST_BADFREE;
                    state_next = S_RES;
                end else begin
                    op = OP_F_MARK;
                    state_next = S_F_LOOP;
                end
            end
            S_F_LOOP: begin
                if (sts.k_top || sts.b_out) begin
                    state_next = S_F_PH1;
                end else begin
                    op = OP_ST_RD_B;
                    state_next = S_F_BCHK;
                end
            end
            S_F_BCHK: state_next = sts.merge_ok ? S_F_ULRD : S_F_PH1;
            S_F_ULRD: begin op = OP_UL_RD; state_next = S_F_ULWR; end
            S_F_ULWR: begin op = OP_UL_WR; state_next = S_F_UP;   end
            S_F_UP:   begin op = OP_F_UP;  state_next = S_F_LOOP; end
            S_F_PH1:  begin op = OP_PH1;   state_next = S_F_PH2;  end
            S_F_PH2: begin
                op = OP_PH2;
                res_next = ST_OK;
                state_next = S_RES;
            end
            S_RES: begin
                if (!mv_reg || m_ready) begin
                    op = OP_RES;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLR_START;
        endcase
        if (pool_wr) state_next = S_CLR_START;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR_START;
            res_reg   <= ST_OK;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            mv_reg    <= mv_next;
        end
    end

    assign cmd     = '{op: op, res: res_reg};
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;

endmodule

// ===== sv/buddy_block_allocator_top.sv =====
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  req_t: req_type, request_bytes, block_unit
// m_        out        m_valid / m_ready  rsp_t: status, result_unit, result_order
// cfg_      in         cfg_we             cfg_idx selects pool_units or size_overhead
//
// One word in flight, from the input accept to m_valid. An allocate splits
// blocks level by level down to the needed order; a free merges with its
// buddy level by level. The split and merge walks are bound by the unit-state
// and link memories, each with one write port and one registered read port.
// After reset and after every pool_units write the unit-state memory is cleared,
// then the pool is carved into blocks from the top order down; s_ready stays
// low meanwhile. A result waiting on m_ready does not hold off the next input
// word; it stalls only the finish of the following one.
module buddy_block_allocator_top
    import bba_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_data,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cmd_t cmd;   // controller -> datapath micro-op
    sts_t sts;   // datapath flags back to controller

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .pool_wr (cfg_we && cfg_idx == CFG_POOL),   // re-carve on pool write
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // memories, list ends, config registers and the output register
    bba_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .m_data    (m_data)
    );

    // one word at a time: ready drops right after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // tail push always runs as a link-write pair
    a_push_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_PT2) |-> ($past(cmd.op) == OP_PT1))
        else $error("tail push second half without first");

    // unlink writes use link data read the cycle before
    a_unlink_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_UL_WR) |-> ($past(cmd.op) == OP_UL_RD))
        else $error("unlink write without link read");

    // no input word taken during the clearing pass
    a_clr_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_CLR) |-> !s_ready)
        else $error("input ready while clearing");

endmodule

// ===== test/buddy_pool_checker.sv =====
`timescale 1ns / 1ps

module buddy_pool_checker
    import bba_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  req_t             s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  rsp_t             m_data,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               fail_cnt,
    output int               n_waiting
);

    localparam int NIL = -1;

    logic [ORD_W-1:0] blk_order [POOL_UNITS];
    bit               blk_free  [POOL_UNITS];
    int               nxt       [POOL_UNITS];
    int               prv       [POOL_UNITS];
    int               head      [NORD];
    int               tail      [NORD];
    int               pool_end;
    int               pool_sz;
    int               overhead;
    rsp_t             pending_grants[$];
    int               bad_cnt;

    assign fail_cnt  = bad_cnt + pending_grants.size();
    assign n_waiting = pending_grants.size();

    function automatic void push_tail(int k, int u);
        nxt[u] = NIL;
        prv[u] = tail[k];
        if (tail[k] == NIL) head[k] = u;
        else nxt[tail[k]] = u;
        tail[k] = u;
    endfunction

    function automatic void push_head(int k, int u);
        prv[u] = NIL;
        nxt[u] = head[k];
        if (head[k] == NIL) tail[k] = u;
        else prv[head[k]] = u;
        head[k] = u;
    endfunction

    function automatic void unlink(int k, int u);
        int n;
        int p;
        n = nxt[u];
        p = prv[u];
        if (p == NIL) head[k] = n;
        else nxt[p] = n;
        if (n == NIL) tail[k] = p;
        else prv[n] = p;
    endfunction

    function automatic void carve_pool();
        int u;
        int k;
        u = 0;
        k = NORD - 1;
        for (int i = 0; i < POOL_UNITS; i++) begin
            blk_order[i] = '0;
            blk_free[i]  = 1'b1;
            nxt[i] = 0;
            prv[i] = 0;
        end
        for (int i = 0; i < NORD; i++) begin
            head[i] = NIL;
            tail[i] = NIL;
        end
        while (k >= 0) begin
            if (u + (1 << k) > pool_sz) begin
                k--;
            end else begin
                blk_order[u] = ORD_W'(k);
                push_tail(k, u);
                u += 1 << k;
            end
        end
        pool_end = u;
    endfunction

    function automatic rsp_t do_allocate(logic [23:0] nbytes);
        rsp_t   r;
        longint total;
        int     ord;
        int     k;
        int     u;
        int     hi;
        r = '0;
        total = ((longint'(nbytes) + 7) & ~longint'(7)) + overhead;
        if (total > (longint'(1) << MAX_BITS)) begin
            r.status = ST_BIG;
            return r;
        end
        ord = 0;
        while (ord < NORD - 1 && (longint'(1) << (MIN_BITS + ord)) < total) ord++;
        k = ord;
        while (k < NORD && head[k] == NIL) k++;
        if (k >= NORD) begin
            r.status       = ST_FULL;
            r.result_order = ORD_W'(ord);
            return r;
        end
        while (k > ord) begin
            u = head[k];
            unlink(k, u);
            k--;
            hi = u + (1 << k);
            blk_order[u] = ORD_W'(k);
            blk_free[u]  = 1'b1;
            push_tail(k, u);
            blk_order[hi] = ORD_W'(k);
            blk_free[hi]  = 1'b1;
            push_tail(k, hi);
        end
        u = head[ord];
        unlink(ord, u);
        blk_free[u]    = 1'b0;
        r.status       = ST_OK;
        r.result_unit  = UNIT_W'(u);
        r.result_order = ORD_W'(ord);
        return r;
    endfunction

    function automatic rsp_t do_release(logic [UNIT_W-1:0] unit);
        rsp_t r;
        int   u;
        int   s;
        int   b;
        r = '0;
        u = int'(unit);
        if (u >= pool_end || blk_free[u]) begin
            r.status = ST_BADFREE;
            return r;
        end
        s = int'(blk_order[u]);
        if (s > NORD - 1) s = NORD - 1;
        blk_free[u] = 1'b1;
        while (s < NORD - 1) begin
            b = u ^ (1 << s);
            if (b >= pool_end || !blk_free[b] || int'(blk_order[b]) != s) break;
            unlink(s, b);
            if (b < u) u = b;
            s++;
            blk_order[u] = ORD_W'(s);
        end
        blk_order[u] = ORD_W'(s);
        push_head(s, u);
        r.status       = ST_OK;
        r.result_unit  = UNIT_W'(u);
        r.result_order = ORD_W'(s);
        return r;
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            pool_sz  = POOL_UNITS;
            overhead = 352;
            carve_pool();
            pending_grants.delete();
            bad_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_grants.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("%t: unexpected result %h", $realtime, m_data);
                end else begin
                    want = pending_grants.pop_front();
                    if (m_data.status != want.status ||
                        m_data.result_unit != want.result_unit ||
                        m_data.result_order != want.result_order) begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display("%t: mismatch status %0d/%0d unit %0d/%0d order %0d/%0d",
                                     $realtime, want.status, m_data.status,
                                     want.result_unit, m_data.result_unit,
                                     want.result_order, m_data.result_order);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.req_type) pending_grants.push_back(do_release(s_data.block_unit));
                else pending_grants.push_back(do_allocate(s_data.request_bytes));
            end
            if (cfg_we) begin
                if (cfg_idx == CFG_POOL) begin
                    pool_sz = int'(cfg_wdata[14:0]);
                    if (pool_sz > POOL_UNITS) pool_sz = POOL_UNITS;
                    carve_pool();
                end else begin
                    overhead = int'(cfg_wdata[11:0]);
                end
            end
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bba_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    req_t             s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    rsp_t             m_data;
    logic             cfg_we = 1'b0;
    logic             cfg_idx = CFG_POOL;
    logic [CFG_W-1:0] cfg_wdata = '0;
    int               fail_cnt;
    int               n_waiting;

    // stimulus bookkeeping
    int               n_sent = 0;
    bit               calm;               // no idling on either side
    bit               held = 1'b0;
    logic             sent_kinds[$];      // req_type of words still in flight
    logic [UNIT_W-1:0] live[$];           // allocated block starts

    always #6 aclk = ~aclk;

    assign calm = (n_sent >= 300 && n_sent < 400);

    buddy_block_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    buddy_pool_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .fail_cnt(fail_cnt), .n_waiting(n_waiting)
    );

    // hard stop: several clears plus ~800 words at worst-case latency and stalls
    initial begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // track granted blocks so frees mostly hit live allocations
    always @(posedge aclk) begin
        logic k;
        if (aresetn) begin
            if (s_valid && s_ready) sent_kinds.push_back(s_data.req_type);
            if (m_valid && m_ready) begin
                k = sent_kinds.pop_front();
                if (!k && m_data.status == ST_OK) live.push_back(m_data.result_unit);
            end
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (!held && n_sent >= 100) begin
                held = 1'b1;
                hold = 600;
            end
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = calm || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic issue(input logic kind, input logic [23:0] nbytes,
                         input logic [UNIT_W-1:0] unit);
        s_data.req_type      = kind;
        s_data.request_bytes = nbytes;
        s_data.block_unit    = unit;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 99) < 25) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (n_waiting != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic free_live(input int idx);
        logic [UNIT_W-1:0] u;
        u = live[idx];
        live.delete(idx);
        issue(1'b1, 24'($urandom), u);
    endtask

    // both registers; overhead first so the pool write's clear comes last
    task automatic set_regs(input int pool, input int ovh);
        drain();
        while (!s_ready) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_idx   = CFG_OVH;
        cfg_wdata = CFG_W'(ovh);
        @(negedge aclk);
        cfg_idx   = CFG_POOL;
        cfg_wdata = CFG_W'(pool);
        @(negedge aclk);
        cfg_we = 1'b0;
        live.delete();
    endtask

    task automatic random_word();
        int r;
        int q;
        logic [23:0] nb;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            q = $urandom_range(0, 9);
            if (q < 6)       nb = 24'($urandom_range(0, 4000));
            else if (q < 8)  nb = 24'($urandom_range(0, 1 << 18));
            else if (q == 8) nb = 24'($urandom_range(0, 1 << 22));
            else             nb = 24'($urandom);
            issue(1'b0, nb, 14'($urandom));
        end else if (r < 90 && live.size() != 0) begin
            free_live($urandom_range(0, live.size() - 1));
        end else if ($urandom_range(0, 1) == 0) begin
            issue(1'b1, 24'($urandom), 14'($urandom_range(0, 31)));
        end else begin
            issue(1'b1, 24'($urandom), 14'($urandom));
        end
    endtask

    initial begin
        int pools[6];
        int ovhs[6];
        pools = '{16384, 0, 32767, 5, 1000, 16384};
        ovhs  = '{352, 0, 4095, 8, 100, 352};

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: default config, extremes of size and the free cases
        issue(1'b0, 24'd0, 14'h3FFF);
        issue(1'b0, 24'd1, 14'd0);
        issue(1'b0, 24'd1000, 14'd0);
        issue(1'b0, 24'((1 << 22) - 352), 14'd0);      // exactly the top order
        issue(1'b0, 24'((1 << 22) - 351), 14'd0);      // one word over after rounding
        issue(1'b0, 24'hFFFFFF, 14'd0);
        drain();
        issue(1'b1, 24'hFFFFFF, 14'h3FFF);             // never allocated
        issue(1'b1, 24'd0, live[0]);                   // free, then the double free
        issue(1'b1, 24'd0, live[0]);
        live.delete(0);
        while (live.size() != 0) free_live(0);
        repeat (5) issue(1'b0, 24'((1 << 22) - 352), 14'd0);  // last one finds no room
        drain();
        while (live.size() != 0) free_live(live.size() - 1);
        drain();

        // random phases across register settings, extremes included
        for (int p = 0; p < 6; p++) begin
            set_regs(pools[p], ovhs[p]);
            repeat (125) random_word();
        end

        drain();
        repeat (150) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bba_pkg.sv
sv/bba_dpath.sv
sv/bba_ctrl.sv
sv/buddy_block_allocator_top.sv
test/buddy_pool_checker.sv
test/tb.sv
